@@ rtl/sfspr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfspr_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] PAYLOAD_CNT = CNT_W'(PAYLOAD_BYTES);

  // sync pattern
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  typedef logic [7:0] byte_t;

  // shift command to the payload chain
  typedef struct packed {
    logic shift_one;
    logic shift_two;
  } cell_ctrl_t;

  // one decoded result
  typedef struct packed {
    logic [15:0] front_dist;
    logic [15:0] left_dist;
    logic [15:0] right_dist;
    logic [15:0] back_dist;
  } dist_t;

endpackage

`default_nettype wire

@@ rtl/sfspr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfspr_cell (
  input  wire logic                 clk_i,
  input  wire sfspr_pkg::cell_ctrl_t ctrl_i,
  input  wire sfspr_pkg::byte_t     nxt1_i,
  input  wire sfspr_pkg::byte_t     nxt2_i,
  output sfspr_pkg::byte_t          data_o,
  output sfspr_pkg::byte_t          data_next_o
);

  sfspr_pkg::byte_t data_q, data_d;

  // take the neighbor one or two places up the chain
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_two) begin
      data_d = nxt2_i;
    end else if (ctrl_i.shift_one) begin
      data_d = nxt1_i;
    end
  end

  // payload byte, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign data_next_o = data_d;

endmodule

`default_nettype wire

@@ rtl/sfspr_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfspr_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sfspr_pkg::dist_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sfspr_pkg::dist_t     out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  sfspr_pkg::dist_t out_q, out_d;
  sfspr_pkg::dist_t skid_q, skid_d;
  logic             take;

  assign take = out_valid_q && !out_stall_i;

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d  = push_i;
        out_d        = push_data_i;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result data
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/sync_framed_sensor_packet_receiver.sv @@
// Sync-framed sensor packet receiver.
// Input channel: one received byte per request on rx_byte_i, taken when
// in_valid_i is high and in_stall_o is low. The block hunts for 0xAA 0x55,
// which opens (or reopens) a frame; eight payload bytes and an 8-bit
// additive checksum follow. A good frame gives one request on the output
// channel carrying four little-endian 16-bit distances; a bad one is dropped.
// Throughput: one byte per cycle while in_stall_o is low. The payload bytes move along a
// row of eight byte cells; per byte only a compare, an 8-bit add and a shift.
// The result is registered in the output buffer before out_valid_o shows it. A
// checksum of 0xAA is held as a possible sync byte, so that frame's result
// is pushed with the next byte instead, or dropped if that byte is 0x55.
// Reset clears the framing state and the output buffer; payload cells are
// not cleared. When out_stall_i holds a result, one more result fits in a
// skid entry; in_stall_o rises only while that entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module sync_framed_sensor_packet_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      front_dist_o,
  output logic [15:0]      left_dist_o,
  output logic [15:0]      right_dist_o,
  output logic [15:0]      back_dist_o
);

  localparam int unsigned NB = sfspr_pkg::PAYLOAD_BYTES;
  localparam int unsigned CW = sfspr_pkg::CNT_W;

  logic          sync_pending_q, sync_pending_d;
  logic          in_packet_q, in_packet_d;
  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [7:0]    running_sum_q, running_sum_d;

  logic          in_acc, buf_full;
  logic          is_second, is_first, restart;
  logic          a_proc, a_store, a_chk, a_hit;
  logic          in_packet_a;
  logic [CW-1:0] count_a;
  logic [7:0]    sum_a;
  logic          b_proc, b_store, b_chk, b_hit;
  logic          result;

  sfspr_pkg::cell_ctrl_t ctrl;
  sfspr_pkg::byte_t      ext [0:NB+1];
  sfspr_pkg::byte_t      cell_next [0:NB-1];
  sfspr_pkg::dist_t      res_data, out_data;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_second = (rx_byte_i == sfspr_pkg::SYNC_SECOND);
  assign is_first  = (rx_byte_i == sfspr_pkg::SYNC_FIRST);
  assign restart   = sync_pending_q && is_second;

  // a held 0xAA not followed by 0x55 counts as a frame byte
  assign a_proc  = sync_pending_q && !is_second && in_packet_q;
  assign a_store = a_proc && (byte_count_q < sfspr_pkg::PAYLOAD_CNT);
  assign a_chk   = a_proc && !(byte_count_q < sfspr_pkg::PAYLOAD_CNT);
  assign a_hit   = a_chk && (running_sum_q == sfspr_pkg::SYNC_FIRST);

  // state after the held byte
  always_comb begin
    in_packet_a = in_packet_q && !a_chk;
    count_a     = byte_count_q;
    sum_a       = running_sum_q;
    if (a_store) begin
      count_a = byte_count_q + CW'(1);
      sum_a   = running_sum_q + sfspr_pkg::SYNC_FIRST;
    end else if (a_chk) begin
      count_a = '0;
    end
  end

  // then the current byte
  assign b_proc  = !restart && !is_first && in_packet_a;
  assign b_store = b_proc && (count_a < sfspr_pkg::PAYLOAD_CNT);
  assign b_chk   = b_proc && !(count_a < sfspr_pkg::PAYLOAD_CNT);
  assign b_hit   = b_chk && (rx_byte_i == sum_a);
  assign result  = in_acc && (a_hit || b_hit);

  // framing state update
  always_comb begin
    sync_pending_d = sync_pending_q;
    in_packet_d    = in_packet_q;
    byte_count_d   = byte_count_q;
    running_sum_d  = running_sum_q;
    if (in_acc) begin
      if (restart) begin
        sync_pending_d = 1'b0;
        in_packet_d    = 1'b1;
        byte_count_d   = '0;
        running_sum_d  = '0;
      end else begin
        sync_pending_d = is_first;
        in_packet_d    = in_packet_a && !b_chk;
        byte_count_d   = count_a;
        running_sum_d  = sum_a;
        if (b_store) begin
          byte_count_d  = count_a + CW'(1);
          running_sum_d = sum_a + rx_byte_i;
        end else if (b_chk) begin
          byte_count_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pending_q <= 1'b0;
      in_packet_q    <= 1'b0;
      byte_count_q   <= '0;
      running_sum_q  <= '0;
    end else begin
      sync_pending_q <= sync_pending_d;
      in_packet_q    <= in_packet_d;
      byte_count_q   <= byte_count_d;
      running_sum_q  <= running_sum_d;
    end
  end

  // chain shift: one or two new bytes enter at the top
  assign ctrl.shift_one = in_acc && (a_store ^ b_store);
  assign ctrl.shift_two = in_acc && a_store && b_store;
  assign ext[NB]   = a_store ? sfspr_pkg::SYNC_FIRST : rx_byte_i;
  assign ext[NB+1] = rx_byte_i;

  // payload cells, oldest byte ends in cell zero
  for (genvar i = 0; i < NB; i++) begin : g_cell
    sfspr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .nxt1_i      (ext[i+1]),
      .nxt2_i      (ext[i+2]),
      .data_o      (ext[i]),
      .data_next_o (cell_next[i])
    );
  end

  // assemble distances from the updated payload
  assign res_data.front_dist = {cell_next[1], cell_next[0]};
  assign res_data.left_dist  = {cell_next[3], cell_next[2]};
  assign res_data.right_dist = {cell_next[5], cell_next[4]};
  assign res_data.back_dist  = {cell_next[7], cell_next[6]};

  sfspr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (result),
    .push_data_i (res_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign in_stall_o   = buf_full;
  assign front_dist_o = out_data.front_dist;
  assign left_dist_o  = out_data.left_dist;
  assign right_dist_o = out_data.right_dist;
  assign back_dist_o  = out_data.back_dist;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= sfspr_pkg::PAYLOAD_CNT)
    else $error("payload count past frame length");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_packet_q |-> (byte_count_q == '0))
    else $error("payload count nonzero outside a frame");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart) |=> (in_packet_q && byte_count_q == '0 && running_sum_q == '0))
    else $error("sync did not restart the frame");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

`default_nettype wire
